/* hw/rtl/tfa_pkg.sv */
`default_nettype none

package tfa_pkg;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Frame layout
    localparam int FRAME_W  = 32;
    localparam int TEMP_LSB = 20;
    localparam int TEMP_W   = 8;

    // Message bytes
    localparam logic [7:0] MARK_CHAR  = 8'h2A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Sequencer steps: opening mark is step zero, fault message closes on step six
    localparam logic [2:0] STEP_OPEN        = 3'd0;
    localparam logic [2:0] STEP_FAULT_CLOSE = 3'd6;

    // One classified request as handed from front to back
    typedef struct packed {
        logic       fault;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } desc_t;

    // Letters of the fault text, indexed by step (one to five)
    function automatic logic [7:0] err_char(input logic [2:0] step);
        logic [7:0] ch;
        unique case (step)
            3'd1:    ch = 8'h45;
            3'd2:    ch = 8'h52;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4F;
            3'd5:    ch = 8'h52;
            default: ch = MARK_CHAR;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tfa_front.sv */
`default_nettype none

module tfa_front (
    input  wire logic [tfa_pkg::FRAME_W-1:0] frame,
    output tfa_pkg::desc_t                   desc
);

    logic [tfa_pkg::TEMP_W-1:0] temp;
    logic [1:0]                 hund;
    logic [6:0]                 rem;
    logic [14:0]                prod;
    logic [3:0]                 tens;
    logic [6:0]                 tens_x10;

    // Split the temperature into hundreds and a remainder below one hundred
    always_comb
    begin
        temp = frame[tfa_pkg::TEMP_LSB +: tfa_pkg::TEMP_W];
        if (temp >= 8'd200)
        begin
            hund = 2'd2;
            rem  = 7'(temp - 8'd200);
        end
        else if (temp >= 8'd100)
        begin
            hund = 2'd1;
            rem  = 7'(temp - 8'd100);
        end
        else
        begin
            hund = 2'd0;
            rem  = temp[6:0];
        end
    end

    // Tens by reciprocal multiply (exact for values below one hundred), ones by subtraction
    always_comb
    begin
        prod       = 15'({8'd0, rem} * 15'd205);
        tens       = prod[14:11];
        tens_x10   = 7'({3'd0, tens} * 7'd10);
        desc.hund  = hund;
        desc.tens  = tens;
        desc.ones  = 4'(rem - tens_x10);
        desc.fault = frame[0];
    end

endmodule

`default_nettype wire

/* hw/rtl/tfa_queue.sv */
`default_nettype none

module tfa_queue #(
    parameter int Depth = tfa_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tfa_pkg::desc_t push_desc,
    output logic                full,
    input  wire logic           pop,
    output tfa_pkg::desc_t      head_desc,
    output logic                head_valid
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    tfa_pkg::desc_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth and update the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CntW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store request payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* hw/rtl/tfa_back.sv */
`default_nettype none

module tfa_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tfa_pkg::desc_t head_desc,
    input  wire logic           head_valid,
    output logic                pop,
    output logic [7:0]          char_out,
    output logic                last,
    output logic                out_valid,
    input  wire logic           out_ready
);

    logic [2:0] step_reg, step_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       valid_reg, valid_next;
    logic       load;
    logic [1:0] num_digits;
    logic [2:0] close_step;
    logic [2:0] digit_sel;
    logic [3:0] digit;
    logic [7:0] byte_val;
    logic       byte_last;

    assign char_out  = char_reg;
    assign last      = last_reg;
    assign out_valid = valid_reg;

    // Load the output register when a request is waiting and the register is empty or being drained
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && byte_last;

    // Work out the byte for the current step of the head request
    always_comb
    begin
        if (head_desc.hund != 2'd0)
        begin
            num_digits = 2'd3;
        end
        else if (head_desc.tens != 4'd0)
        begin
            num_digits = 2'd2;
        end
        else
        begin
            num_digits = 2'd1;
        end
        close_step = head_desc.fault ? tfa_pkg::STEP_FAULT_CLOSE : 3'({1'b0, num_digits} + 3'd1);
        digit_sel  = 3'(step_reg + {1'b0, 2'(2'd3 - num_digits)});
        case (digit_sel)
            3'd1:    digit = {2'd0, head_desc.hund};
            3'd2:    digit = head_desc.tens;
            default: digit = head_desc.ones;
        endcase
        byte_last = (step_reg == close_step);
        if (step_reg == tfa_pkg::STEP_OPEN || byte_last)
        begin
            byte_val = tfa_pkg::MARK_CHAR;
        end
        else if (head_desc.fault)
        begin
            byte_val = tfa_pkg::err_char(step_reg);
        end
        else
        begin
            byte_val = 8'(tfa_pkg::ASCII_ZERO + {4'd0, digit});
        end
    end

    // Advance the step, drop back to the opening mark after the closing byte, and update the valid flag
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            step_next  = byte_last ? tfa_pkg::STEP_OPEN : 3'(step_reg + 3'd1);
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= tfa_pkg::STEP_OPEN;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the output byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= byte_val;
            last_reg <= byte_last;
        end
    end

    a_last_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (char_reg == tfa_pkg::MARK_CHAR))
        else $error("closing byte is not a mark");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= tfa_pkg::STEP_FAULT_CLOSE)
        else $error("step beyond closing byte");

    a_pop_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == tfa_pkg::STEP_OPEN))
        else $error("step not back at opening mark after request done");

endmodule

`default_nettype wire

/* hw/rtl/thermocouple_frame_to_ascii_core.sv */
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid, in_ready   | frame[31:0]
// output  | out       | out_valid, out_ready | char_out[7:0], last
//
// A frame is classified in its accept cycle and queued; one message byte leaves per cycle while out_ready is high.
// Its message is three to five bytes long, or seven bytes (mark, ERROR, mark) on a fault.
// The sequencer sets the rate; the queue lets frames be taken while a message is sent.
// Reset clears the queue, the sequencer step and the output valid flag.
// A stalled output holds its byte; in_ready falls only when the queue is full.
`default_nettype none

module thermocouple_frame_to_ascii_core #(
    parameter int QueueDepth = tfa_pkg::QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [tfa_pkg::FRAME_W-1:0]  frame,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic [7:0]                        char_out,
    output logic                              last,
    output logic                              out_valid,
    input  wire logic                         out_ready
);

    tfa_pkg::desc_t new_desc;
    tfa_pkg::desc_t head_desc;
    logic           full;
    logic           head_valid;
    logic           pop;

    assign in_ready = !full;

    // Classify the incoming frame
    tfa_front u_front (
        .frame (frame),
        .desc  (new_desc)
    );

    // Queue classified requests
    tfa_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !full),
        .push_desc  (new_desc),
        .full       (full),
        .pop        (pop),
        .head_desc  (head_desc),
        .head_valid (head_valid)
    );

    // Send message bytes
    tfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .pop        (pop),
        .char_out   (char_out),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

`default_nettype wire
